// ===== sv/vps_pkg.sv =====
// ----------------------------------------------------------------------------
// vps_pkg
// Shared widths, codes and defaults for the voxel perspective splat block.
// ----------------------------------------------------------------------------
package vps_pkg;

    // signed Q4.16 vector component and packed three-component register
    localparam int VW    = 21;
    localparam int VEC_W = 3 * VW;
    localparam int TAN_W = 24;

    // iterative divider: |q| * 2^16 over the distance
    localparam int NUM_W = 63;
    localparam int DEN_W = 30;

    // iterative square root of the squared distance
    localparam int SQ_W   = 64;
    localparam int ROOT_W = SQ_W / 2;

    localparam int DEF_IMAGE_ROWS = 256;
    localparam int DEF_IMAGE_COLS = 256;
    localparam int DEF_GRID_SIZE  = 256;

    // input beat actions
    typedef enum logic [1:0] {
        ACT_SPLAT    = 2'd0,
        ACT_READ     = 2'd1,
        ACT_READ_CLR = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CAM  = 3'd0,
        REG_NRM  = 3'd1,
        REG_EH   = 3'd2,
        REG_EV   = 3'd3,
        REG_TAN  = 3'd4,
        REG_ORG  = 3'd5,
        REG_STEP = 3'd6
    } t_reg_index;

endpackage

// ===== sv/voxel_perspective_splat.sv =====
// ----------------------------------------------------------------------------
// voxel_perspective_splat
// Perspective splatting of voxels into a saturating image store.
// ----------------------------------------------------------------------------
// One beat at a time: the block is ready only while idle. A splat beat that
// reaches the image passes through the accept, twenty-two products on the
// shared 44x30 multiplier, the 32-step square root, each of the two 63-step
// divisions (one per image axis), and the store read, store write and output
// hand-off. A voxel that misses leaves as soon as the miss is known. Empty or
// out-of-grid voxels and reads skip the arithmetic. A result that cannot enter
// the output register holds the block in its last state until the register
// frees. After reset the block walks the image store once to zero it, one
// pixel a cycle, and is not ready until then; configuration writes are taken
// at any time. A finished result waits in the output register, so the next
// beat may be accepted before it is drained.
// ----------------------------------------------------------------------------
module voxel_perspective_splat #(
    parameter int IMAGE_ROWS = vps_pkg::DEF_IMAGE_ROWS,
    parameter int IMAGE_COLS = vps_pkg::DEF_IMAGE_COLS,
    parameter int GRID_SIZE  = vps_pkg::DEF_GRID_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input: voxel_i[7:0], voxel_j[15:8], voxel_k[23:16], voxel_value[39:24],
    //        pixel_row[47:40], pixel_col[55:48]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // output: image_row[7:0], image_col[15:8], pixel_value[47:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,
    // hit[0]
    output logic        o_m_axis_tuser,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [vps_pkg::VEC_W-1:0] i_cfg_data
);

    localparam int DEPTH = IMAGE_ROWS * IMAGE_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(IMAGE_ROWS);
    localparam int CW    = $clog2(IMAGE_COLS);
    localparam int VW    = vps_pkg::VW;

    localparam logic signed [63:0] ONE32   = 64'sh1_0000_0000;
    localparam logic signed [63:0] TWO33   = 64'sh2_0000_0000;
    localparam logic [62:0]        R_CLAMP = 63'h40_0000_0000;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_RCP_M, S_RCP_A, S_D2_M, S_D2_A, S_F_M, S_F_A, S_Q_M, S_Q_A,
        S_E1_M, S_E1_A, S_E2_M, S_E2_A, S_SQRT, S_DIV,
        S_U_M, S_U_A, S_P_M, S_P_A, S_MEM_RD, S_MEM_WAIT, S_DONE
    } t_state;

    function automatic logic signed [VW-1:0] comp(input logic [vps_pkg::VEC_W-1:0] v,
                                                  input logic [1:0] a);
        case (a)
            2'd0:    comp = v[VW-1:0];
            2'd1:    comp = v[2*VW-1:VW];
            default: comp = v[3*VW-1:2*VW];
        endcase
    endfunction

    t_state r_state;

    // configuration
    logic [vps_pkg::VEC_W-1:0] r_cam, r_nrm, r_eh, r_ev, r_org, r_stp;
    logic [vps_pkg::TAN_W-1:0] r_tan;

    // latched beat
    logic [1:0]  r_act;
    logic [7:0]  r_idx [3];
    logic [15:0] r_val;

    // datapath
    logic [1:0]          r_cnt;
    logic                r_axis;
    logic signed [73:0]  r_prod;
    logic signed [63:0]  r_acc;
    logic [63:0]         r_d2;
    logic signed [29:0]  r_rcp [3];
    logic signed [35:0]  r_f;
    logic signed [43:0]  r_q [3];
    logic signed [47:0]  r_q1, r_q2;
    logic [vps_pkg::DEN_W-1:0] r_d;
    logic signed [39:0]  r_r;
    logic signed [34:0]  r_v;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_clr;
    logic                r_sq_start, r_dv_start;

    // result and output register
    logic        r_res_hit;
    logic [7:0]  r_res_row, r_res_col;
    logic [31:0] r_res_pix;
    logic        r_out_valid, r_out_hit;
    logic [7:0]  r_out_row, r_out_col;
    logic [31:0] r_out_pix;

    // image store
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;
    logic        w_mem_we;
    logic [AW-1:0] w_mem_wa;
    logic [31:0] w_mem_wd;

    logic signed [43:0] w_ma;
    logic signed [29:0] w_mb;
    logic signed [63:0] w_prod64, w_sum, w_v;
    logic signed [47:0] w_qsel, w_qabs;
    logic [vps_pkg::NUM_W-1:0] w_div_num, w_quo, w_mag;
    logic               sq_done, dv_done;
    logic [vps_pkg::ROOT_W-1:0] sq_root;
    logic [12:0]        w_p;
    logic               w_p_hit;
    logic [32:0]        w_sat_sum;
    logic [31:0]        w_sat;
    logic               w_accept;
    logic [7:0]         w_in_idx [3];
    logic [15:0]        w_in_val;
    logic [7:0]         w_in_row, w_in_col;
    logic               w_grid_ok, w_pix_ok;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_idx[0] = i_s_axis_tdata[7:0];
    assign w_in_idx[1] = i_s_axis_tdata[15:8];
    assign w_in_idx[2] = i_s_axis_tdata[23:16];
    assign w_in_val    = i_s_axis_tdata[39:24];
    assign w_in_row    = i_s_axis_tdata[47:40];
    assign w_in_col    = i_s_axis_tdata[55:48];
    assign w_grid_ok   = (32'(w_in_idx[0]) < 32'(GRID_SIZE))
                      && (32'(w_in_idx[1]) < 32'(GRID_SIZE))
                      && (32'(w_in_idx[2]) < 32'(GRID_SIZE));
    assign w_pix_ok    = (32'(w_in_row) < 32'(IMAGE_ROWS))
                      && (32'(w_in_col) < 32'(IMAGE_COLS));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = {r_out_pix, r_out_col, r_out_row};

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_RCP_M: begin
                w_ma = $signed({36'd0, r_idx[r_cnt]});
                w_mb = 30'(comp(r_stp, r_cnt));
            end
            S_D2_M: begin
                w_ma = 44'(r_rcp[r_cnt]);
                w_mb = r_rcp[r_cnt];
            end
            S_F_M: begin
                w_ma = 44'(r_rcp[r_cnt]);
                w_mb = 30'(comp(r_nrm, r_cnt));
            end
            S_Q_M: begin
                w_ma = 44'(r_f);
                w_mb = 30'(comp(r_nrm, r_cnt));
            end
            S_E1_M: begin
                w_ma = r_q[r_cnt];
                w_mb = 30'(comp(r_eh, r_cnt));
            end
            S_E2_M: begin
                w_ma = r_q[r_cnt];
                w_mb = 30'(comp(r_ev, r_cnt));
            end
            S_U_M: begin
                w_ma = 44'(r_r);
                w_mb = $signed({6'd0, r_tan});
            end
            S_P_M: begin
                w_ma = 44'(r_v);
                w_mb = r_axis ? $signed(30'(IMAGE_COLS)) : $signed(30'(IMAGE_ROWS));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod64 = 64'(r_prod);
    assign w_sum    = r_acc + w_prod64;
    assign w_v      = w_prod64 + ONE32;

    // row axis first from q2, then column axis from q1
    assign w_qsel    = r_axis ? r_q1 : r_q2;
    assign w_qabs    = w_qsel[47] ? -w_qsel : w_qsel;
    assign w_div_num = {w_qabs[46:0], 16'd0};
    assign w_mag     = (w_quo > R_CLAMP) ? R_CLAMP : w_quo;

    // image index: truncate N*v / 2^33 toward zero; negatives hit only at zero
    assign w_p     = w_prod64[63] ? 13'd0 : w_prod64[45:33];
    assign w_p_hit = w_prod64[63] ? (w_prod64 > -TWO33)
                   : (32'(w_p) < (r_axis ? 32'(IMAGE_COLS) : 32'(IMAGE_ROWS)));

    assign w_sat_sum = {1'b0, r_rdata} + 33'(r_val);
    assign w_sat     = w_sat_sum[32] ? 32'hFFFF_FFFF : w_sat_sum[31:0];

    assign w_mem_we = (r_state == S_CLEAR)
                   || ((r_state == S_MEM_WAIT)
                       && (r_act == vps_pkg::ACT_SPLAT || r_act == vps_pkg::ACT_READ_CLR));
    assign w_mem_wa = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign w_mem_wd = ((r_state == S_MEM_WAIT) && (r_act == vps_pkg::ACT_SPLAT))
                    ? w_sat : 32'd0;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_rdata <= r_mem[r_addr];
    end

    vps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_x     (r_d2),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    vps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dv_start),
        .i_num   (w_div_num),
        .i_den   (r_d),
        .o_done  (dv_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_sq_start  <= 1'b0;
            r_dv_start  <= 1'b0;
            r_cam       <= '0;
            r_nrm       <= '0;
            r_eh        <= '0;
            r_ev        <= '0;
            r_org       <= '0;
            r_stp       <= '0;
            r_tan       <= vps_pkg::TAN_W'(65536);
        end else begin
            // launch the root after the last vertical product, a division
            // once the distance is known and again after a row hit
            r_sq_start <= (r_state == S_E2_A) && (r_cnt == 2'd2);
            r_dv_start <= ((r_state == S_SQRT) && sq_done && (sq_root != '0))
                       || ((r_state == S_P_A) && w_p_hit && !r_axis);
            // a result waiting to load keeps the output valid; drop it once taken
            r_out_valid <= (r_state == S_DONE) || (r_out_valid && !i_m_axis_tready);
            r_prod     <= w_ma * w_mb;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    vps_pkg::REG_CAM:  r_cam <= i_cfg_data;
                    vps_pkg::REG_NRM:  r_nrm <= i_cfg_data;
                    vps_pkg::REG_EH:   r_eh  <= i_cfg_data;
                    vps_pkg::REG_EV:   r_ev  <= i_cfg_data;
                    vps_pkg::REG_TAN:  r_tan <= i_cfg_data[vps_pkg::TAN_W-1:0];
                    vps_pkg::REG_ORG:  r_org <= i_cfg_data;
                    vps_pkg::REG_STEP: r_stp <= i_cfg_data;
                    default:  ;
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_act     <= i_s_axis_tuser;
                        r_idx[0]  <= w_in_idx[0];
                        r_idx[1]  <= w_in_idx[1];
                        r_idx[2]  <= w_in_idx[2];
                        r_val     <= w_in_val;
                        r_cnt     <= 2'd0;
                        r_acc     <= '0;
                        r_d2      <= '0;
                        r_res_hit <= 1'b0;
                        r_res_pix <= 32'd0;
                        case (i_s_axis_tuser)
                            vps_pkg::ACT_SPLAT: begin
                                r_res_row <= 8'd0;
                                r_res_col <= 8'd0;
                                // drop empty or off-grid voxels at once
                                if (w_in_val != 16'd0 && w_grid_ok) begin
                                    r_state <= S_RCP_M;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            vps_pkg::ACT_READ, vps_pkg::ACT_READ_CLR: begin
                                r_res_row <= w_in_row;
                                r_res_col <= w_in_col;
                                r_addr    <= AW'(32'(w_in_row) * 32'(IMAGE_COLS)
                                                 + 32'(w_in_col));
                                r_state   <= w_pix_ok ? S_MEM_RD : S_DONE;
                            end
                            default: begin
                                r_res_row <= 8'd0;
                                r_res_col <= 8'd0;
                                r_state   <= S_DONE;
                            end
                        endcase
                    end
                end
                // relative position: origin + index * step - camera
                S_RCP_M: r_state <= S_RCP_A;
                S_RCP_A: begin
                    r_rcp[r_cnt] <= 30'(32'(comp(r_org, r_cnt)) + 32'(r_prod)
                                        - 32'(comp(r_cam, r_cnt)));
                    r_cnt   <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 1'b1;
                    r_state <= (r_cnt == 2'd2) ? S_D2_M : S_RCP_M;
                end
                // squared distance
                S_D2_M: r_state <= S_D2_A;
                S_D2_A: begin
                    r_d2    <= r_d2 + w_prod64;
                    r_cnt   <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 1'b1;
                    r_state <= (r_cnt == 2'd2) ? S_F_M : S_D2_M;
                end
                // normal component
                S_F_M: r_state <= S_F_A;
                S_F_A: begin
                    if (r_cnt == 2'd2) begin
                        r_f     <= 36'(w_sum >>> 16);
                        r_acc   <= '0;
                        r_cnt   <= 2'd0;
                        r_state <= S_Q_M;
                    end else begin
                        r_acc   <= w_sum;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_F_M;
                    end
                end
                // remove normal component
                S_Q_M: r_state <= S_Q_A;
                S_Q_A: begin
                    r_q[r_cnt] <= 44'(64'(r_rcp[r_cnt]) - (w_prod64 >>> 16));
                    r_cnt   <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 1'b1;
                    r_state <= (r_cnt == 2'd2) ? S_E1_M : S_Q_M;
                end
                // project on horizontal basis
                S_E1_M: r_state <= S_E1_A;
                S_E1_A: begin
                    if (r_cnt == 2'd2) begin
                        r_q1    <= 48'(w_sum >>> 16);
                        r_acc   <= '0;
                        r_cnt   <= 2'd0;
                        r_state <= S_E2_M;
                    end else begin
                        r_acc   <= w_sum;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_E1_M;
                    end
                end
                // project on vertical basis, then launch the root
                S_E2_M: r_state <= S_E2_A;
                S_E2_A: begin
                    if (r_cnt == 2'd2) begin
                        r_q2       <= 48'(w_sum >>> 16);
                        r_cnt      <= 2'd0;
                        r_state    <= S_SQRT;
                    end else begin
                        r_acc   <= w_sum;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_E2_M;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        if (sq_root == '0) begin
                            // voxel at the camera: miss
                            r_state <= S_DONE;
                        end else begin
                            r_d        <= sq_root[vps_pkg::DEN_W-1:0];
                            r_axis     <= 1'b0;
                            r_state    <= S_DIV;
                        end
                    end
                end
                // divide by distance, restore sign, clamp
                S_DIV: begin
                    if (dv_done) begin
                        r_r     <= w_qsel[47] ? -$signed(40'(w_mag)) : $signed(40'(w_mag));
                        r_state <= S_U_M;
                    end
                end
                S_U_M: r_state <= S_U_A;
                S_U_A: begin
                    r_v <= 35'(w_v);
                    if (w_v >= TWO33 || w_v <= -TWO33) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_P_M;
                    end
                end
                S_P_M: r_state <= S_P_A;
                S_P_A: begin
                    if (!w_p_hit) begin
                        r_state <= S_DONE;
                    end else if (!r_axis) begin
                        r_row      <= RW'(w_p);
                        r_axis     <= 1'b1;
                        r_state    <= S_DIV;
                    end else begin
                        r_col   <= CW'(w_p);
                        r_addr  <= AW'(32'(r_row) * 32'(IMAGE_COLS) + 32'(w_p));
                        r_state <= S_MEM_RD;
                    end
                end
                S_MEM_RD: r_state <= S_MEM_WAIT;
                S_MEM_WAIT: begin
                    if (r_act == vps_pkg::ACT_SPLAT) begin
                        r_res_hit <= 1'b1;
                        r_res_row <= 8'(r_row);
                        r_res_col <= 8'(r_col);
                        r_res_pix <= w_sat;
                    end else begin
                        r_res_pix <= r_rdata;
                    end
                    r_state <= S_DONE;
                end
                // hold until the output register is free
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_hit   <= r_res_hit;
                        r_out_row   <= r_res_row;
                        r_out_col   <= r_res_col;
                        r_out_pix   <= r_res_pix;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/vps_sqrt.sv =====
// ----------------------------------------------------------------------------
// vps_sqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vps_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vps_pkg::SQ_W-1:0]      i_x,
    output logic                          o_done,
    output logic [vps_pkg::ROOT_W-1:0]    o_root
);

    logic [vps_pkg::SQ_W-1:0] r_x;
    logic [vps_pkg::SQ_W-1:0] r_r;
    logic [vps_pkg::SQ_W-1:0] r_b;
    logic                     r_busy;
    logic                     r_done;
    logic [vps_pkg::SQ_W-1:0] w_t;

    assign w_t    = r_r + r_b;
    assign o_done = r_done;
    assign o_root = r_r[vps_pkg::ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_r    <= '0;
                r_b    <= {2'b01, {(vps_pkg::SQ_W-2){1'b0}}};
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x >= w_t) begin
                    r_x <= r_x - w_t;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b <= r_b >> 2;
                if (r_b[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/vps_div.sv =====
// ----------------------------------------------------------------------------
// vps_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vps_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vps_pkg::NUM_W-1:0]     i_num,
    input  logic [vps_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [vps_pkg::NUM_W-1:0]     o_quo
);

    localparam int CNT_W = $clog2(vps_pkg::NUM_W);

    logic [vps_pkg::NUM_W-1:0] r_quo;
    logic [vps_pkg::DEN_W-1:0] r_rem;
    logic [vps_pkg::DEN_W-1:0] r_den;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [vps_pkg::DEN_W:0]   w_sh;
    logic                      w_ge;
    logic [vps_pkg::DEN_W:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[vps_pkg::NUM_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(vps_pkg::NUM_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[vps_pkg::DEN_W-1:0] : w_sh[vps_pkg::DEN_W-1:0];
                r_quo <= {r_quo[vps_pkg::NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
